// ----- hw/rtl/erp2d_pkg.sv -----
`default_nettype none
package erp2d_pkg;

	// Sine polynomial coefficients, Q.15.
	localparam logic [16:0] POLY_A = 17'd51472;
	localparam logic [16:0] POLY_B = 17'd21024;
	localparam logic [16:0] POLY_C = 17'd2320;
	localparam logic [16:0] TRIG_ONE = 17'd32768;

	// Output width and limits.
	localparam int OUT_W = 18;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
	localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

	// Fixed port widths of the channels.
	localparam int FIELD_W = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] point_x;
		logic [FIELD_W-1:0] point_y;
		logic [FIELD_W-1:0] point_z;
		logic [FIELD_W-1:0] angle_about_x;
		logic [FIELD_W-1:0] angle_about_y;
		logic [FIELD_W-1:0] angle_about_z;
		logic               pick_y;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] rotated_value;
	} out_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/erp2d_if.sv -----
`default_nettype none
interface erp2d_in_if;
	import erp2d_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface erp2d_out_if;
	import erp2d_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/erp2d_trig_cell.sv -----
`default_nettype none
// One cell of the sine pipeline. The stage select picks which of the
// polynomial steps this cell performs; each cell registers its result and
// passes it on to the next cell in every enabled cycle.
module erp2d_trig_cell #(
	parameter int STEP = 0
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [16:0] t_in,
	input  wire logic [16:0] acc_in,
	input  wire logic [16:0] t2_in,
	output logic      [16:0] t_out,
	output logic      [16:0] acc_out,
	output logic      [16:0] t2_out
);
	import erp2d_pkg::*;

	logic [33:0] prod;
	logic [16:0] acc_d;
	logic [16:0] t2_d;

	// Step 0: t2 = t*t. Step 1: inner = B - t2*C. Step 2: mid = A - t2*inner.
	// Step 3: r = t*mid, clamped to one.
	always_comb begin
		t2_d = t2_in;
		acc_d = acc_in;
		prod = '0;
		case (STEP)
			0: begin
				prod = t_in * t_in;
				t2_d = prod[31:15];
			end
			1: begin
				prod = t2_in * POLY_C;
				acc_d = POLY_B - prod[31:15];
			end
			2: begin
				prod = t2_in * acc_in;
				acc_d = POLY_A - prod[31:15];
			end
			default: begin
				prod = t_in * acc_in;
				acc_d = (prod[33:15] > {2'b00, TRIG_ONE}) ? TRIG_ONE : prod[31:15];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_out <= t_in;
			t2_out <= t2_d;
			acc_out <= acc_d;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/erp2d_rot_cell.sv -----
`default_nettype none
// Rotation cell: a*ca + b*cb, rounded to the input scale. Products are
// registered before the sum, and the rounded sum is registered again.
module erp2d_rot_cell #(
	parameter int VW = 18
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [VW-1:0] a,
	input  wire logic signed [17:0]   ca,
	input  wire logic signed [VW-1:0] b,
	input  wire logic signed [17:0]   cb,
	output logic signed [VW+3:0]      res
);
	logic signed [VW+17:0] pa_q;
	logic signed [VW+17:0] pb_q;
	logic signed [VW+18:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_q <= a * ca;
			pb_q <= b * cb;
		end
	end

	// Round half up, then floor shift.
	assign sum = VW'(0) + pa_q + pb_q + (VW+19)'(16384);

	always_ff @(posedge clk) begin
		if (en) begin
			res <= sum[VW+18:15];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/euler_rotate_project_2d.sv -----
`default_nettype none
// Channel  Dir  Payload
// in       in   point_x/y/z, angle_about_x/y/z, pick_y
// out      out  rotated_value
//
// One item enters per cycle while out is not stalled. The path runs through
// angle prep, the four sine polynomial cells, then three rotation cells that
// each register their products and then their sum, and a saturation register.
// All stages advance together when the output slot is free or about to empty;
// a stall on out holds the whole chain. Reset clears only the valid bits of the chain.
module euler_rotate_project_2d #(
	parameter int SAMPLE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	erp2d_in_if.sink   in_ch,
	erp2d_out_if.source out_ch
);
	import erp2d_pkg::*;

	localparam int LAT = 12;
	localparam int NT = 6;

	logic [LAT-1:0] vld_q;
	logic           en;

	assign en = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// Angle prep: six angles (sin and cos of each axis) to t and quadrant.
	logic [ANGLE_BITS-1:0] ang [NT];
	logic [16:0] t_s1 [NT];
	logic [1:0]  q_s1 [NT];

	always_comb begin
		ang[0] = in_ch.data.angle_about_x[ANGLE_BITS-1:0];
		ang[1] = ang[0] + (ANGLE_BITS)'(1 << (ANGLE_BITS-2));
		ang[2] = in_ch.data.angle_about_y[ANGLE_BITS-1:0];
		ang[3] = ang[2] + (ANGLE_BITS)'(1 << (ANGLE_BITS-2));
		ang[4] = in_ch.data.angle_about_z[ANGLE_BITS-1:0];
		ang[5] = ang[4] + (ANGLE_BITS)'(1 << (ANGLE_BITS-2));
	end

	for (genvar i = 0; i < NT; i++) begin : g_trig
		logic [ANGLE_BITS-3:0] frac;
		logic [16:0] t_raw;
		logic [16:0] tt [5];
		logic [16:0] aa [5];
		logic [16:0] t2 [5];
		logic [1:0]  qd [5];
		assign frac = ang[i][ANGLE_BITS-3:0];
		if (ANGLE_BITS - 2 >= 15) begin : g_down
			assign t_raw = 17'(frac >> (ANGLE_BITS - 17));
		end else begin : g_up
			assign t_raw = 17'({frac, {(17 - ANGLE_BITS){1'b0}}});
		end
		// Stage 1: quadrant fold.
		always_ff @(posedge clk) begin
			if (en) begin
				q_s1[i] <= ang[i][ANGLE_BITS-1:ANGLE_BITS-2];
				t_s1[i] <= ang[i][ANGLE_BITS-2] ? TRIG_ONE - t_raw : t_raw;
			end
		end
		assign tt[0] = t_s1[i];
		assign aa[0] = '0;
		assign t2[0] = '0;
		for (genvar k = 0; k < 4; k++) begin : g_cell
			erp2d_trig_cell #(.STEP(k)) u_cell (
				.clk(clk), .en(en), .t_in(tt[k]), .acc_in(aa[k]), .t2_in(t2[k]),
				.t_out(tt[k+1]), .acc_out(aa[k+1]), .t2_out(t2[k+1])
			);
		end
		// Quadrant sign follows the value down the cells.
		assign qd[0] = q_s1[i];
		for (genvar k = 0; k < 4; k++) begin : g_qd
			always_ff @(posedge clk) begin
				if (en) qd[k+1] <= qd[k];
			end
		end
		logic signed [17:0] trig_v;
		assign trig_v = qd[4][1] ? -$signed({1'b0, aa[4]}) : $signed({1'b0, aa[4]});
	end

	// Point delay alongside the trig cells (stage 1 plus four cells).
	localparam int PD = 5;
	logic signed [SAMPLE_BITS-1:0] pxd [PD], pyd [PD], pzd [PD];
	logic pkd [PD];
	always_ff @(posedge clk) begin
		if (en) begin
			pxd[0] <= in_ch.data.point_x[SAMPLE_BITS-1:0];
			pyd[0] <= in_ch.data.point_y[SAMPLE_BITS-1:0];
			pzd[0] <= in_ch.data.point_z[SAMPLE_BITS-1:0];
			pkd[0] <= in_ch.data.pick_y;
			for (int k = 1; k < PD; k++) begin
				pxd[k] <= pxd[k-1];
				pyd[k] <= pyd[k-1];
				pzd[k] <= pzd[k-1];
				pkd[k] <= pkd[k-1];
			end
		end
	end

	logic signed [17:0] sx, cx, sy, cy, sz, cz;
	assign sx = g_trig[0].trig_v;
	assign cx = g_trig[1].trig_v;
	assign sy = g_trig[2].trig_v;
	assign cy = g_trig[3].trig_v;
	assign sz = g_trig[4].trig_v;
	assign cz = g_trig[5].trig_v;

	// Rotation about X (stage pair A).
	localparam int VA = SAMPLE_BITS;
	logic signed [VA+3:0] y1, z1;
	erp2d_rot_cell #(.VW(VA)) u_rx_y (
		.clk(clk), .en(en), .a(pyd[PD-1]), .ca(cx), .b(pzd[PD-1]), .cb(-sx), .res(y1)
	);
	erp2d_rot_cell #(.VW(VA)) u_rx_z (
		.clk(clk), .en(en), .a(pyd[PD-1]), .ca(sx), .b(pzd[PD-1]), .cb(cx), .res(z1)
	);

	// Carry what the next steps still need through the X rotation, and on through the Y rotation for Z.
	logic signed [SAMPLE_BITS-1:0] px_a [2];
	logic signed [17:0] sy_a [2], cy_a [2], sz_a [4], cz_a [4];
	logic pk_a [4];
	logic signed [VA+3:0] y1_b [2];
	always_ff @(posedge clk) begin
		if (en) begin
			px_a[0] <= pxd[PD-1];
			px_a[1] <= px_a[0];
			sy_a[0] <= sy;
			sy_a[1] <= sy_a[0];
			cy_a[0] <= cy;
			cy_a[1] <= cy_a[0];
			sz_a[0] <= sz;
			cz_a[0] <= cz;
			pk_a[0] <= pkd[PD-1];
			for (int k = 1; k < 4; k++) begin
				sz_a[k] <= sz_a[k-1];
				cz_a[k] <= cz_a[k-1];
				pk_a[k] <= pk_a[k-1];
			end
			y1_b[0] <= y1;
			y1_b[1] <= y1_b[0];
		end
	end

	// Rotation about Y: only the new x is needed.
	localparam int VB = SAMPLE_BITS + 4;
	logic signed [VB+3:0] x2;
	erp2d_rot_cell #(.VW(VB)) u_ry (
		.clk(clk), .en(en), .a(VB'(px_a[1])), .ca(cy_a[1]), .b(VB'(z1)), .cb(sy_a[1]),
		.res(x2)
	);

	// Rotation about Z, choosing the output coordinate.
	localparam int VC = SAMPLE_BITS + 8;
	logic signed [VC+3:0] r;
	logic signed [17:0] c_a, c_b;
	assign c_a = pk_a[3] ? sz_a[3] : cz_a[3];
	assign c_b = pk_a[3] ? cz_a[3] : -sz_a[3];
	erp2d_rot_cell #(.VW(VC)) u_rz (
		.clk(clk), .en(en), .a(VC'(x2)), .ca(c_a), .b(VC'(y1_b[1])), .cb(c_b), .res(r)
	);

	// Saturate into the output register.
	logic signed [OUT_W-1:0] res_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (r > (VC+4)'(OUT_MAX)) res_q <= OUT_MAX;
			else if (r < (VC+4)'(OUT_MIN)) res_q <= OUT_MIN;
			else res_q <= r[OUT_W-1:0];
		end
	end

	assign out_ch.valid = vld_q[LAT-1];
	assign out_ch.data.rotated_value = res_q;
endmodule
`default_nettype wire

// ----- hw/rtl/erp2d_checker.sv -----
`default_nettype none
module erp2d_sva (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	// The input is taken whenever the result slot drains.
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input stalled");
	// A full output slot with no taker blocks the input.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready) else $error("overrun");
	// A rising result requires reset to have been released before it.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n)) else $error("invented result");
endmodule

bind euler_rotate_project_2d erp2d_sva u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
`default_nettype wire
